/* hw/rtl/tws_pkg.sv */
// shared types and constants for the trie word insert/search block
// letter decoding and result status codes; no dependencies
package tws_pkg;

   localparam int ALPHABET = 52;
   localparam int CODE_W   = 6;
   localparam int HALF_ALPHABET = 26;

   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_Z = 8'h5A;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_POOL_FULL  = 2'd1,
      STATUS_BAD_LETTER = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } letter_code_type;

   // A-Z to 0..25, a-z to 26..51, anything else invalid
   function automatic letter_code_type letter_decode(input logic [7:0] c);
      letter_code_type res;
      logic [7:0]      diff;
      res  = '0;
      diff = '0;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         diff      = c - UPPER_A;
         res.valid = 1'b1;
         res.code  = diff[CODE_W-1:0];
      end else if (c >= LOWER_A && c <= LOWER_Z) begin
         diff      = c - LOWER_A + 8'(HALF_ALPHABET);
         res.valid = 1'b1;
         res.code  = diff[CODE_W-1:0];
      end
      return res;
   endfunction

endpackage

/* hw/rtl/trie_word_insert_search.sv */
// top level of the trie word insert/search block: node row memory and sequencer
// depends on tws_pkg
//
// Dictionary trie that takes words one letter per item. Each node is one row of the
// node memory: for each of the 52 letters it keeps a child index (zero = no child) and
// a word-end bit that marks the child as the end of a stored word. A letter first reads
// the current node's row, then selects the link, decides, and writes the row back. An
// insert letter that allocates a new node then goes through a clear state, in which the
// new node's row is written to all zero, so the memory needs no clearing sweep; the only
// start-up cost is the init state after reset that clears the root row. A result item
// comes only on a word's last letter; the result register lets the next letter in while
// a result waits, and a last letter stalls in its evaluate cycle only while the previous
// result is still not taken. The node pool holds MAX_NODES nodes, root included.
module trie_word_insert_search #(
   parameter int MAX_NODES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   // input items: one letter each
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_letter,
   input  logic       req_last_letter,
   // result items: one per word
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [1:0] rsp_status
);

   // node index width, counter width (can hold MAX_NODES itself), memory row layout
   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int NU_W   = $clog2(MAX_NODES + 1);
   localparam int ENT_W  = NODE_W + 1;
   localparam int ROW_W  = tws_pkg::ALPHABET * ENT_W;

   localparam logic       FUNC_INSERT = 1'b0;
   localparam logic       FUNC_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_INIT,   // clear the root row after reset
      ST_IDLE,   // wait for a letter, read the current node row
      ST_EVAL,   // follow or allocate the link, write back
      ST_CLEAR   // zero the row of a freshly allocated node
   } state_type;

   // one link slot: word-end bit of the child and the child index
   typedef struct packed {
      logic              word_end;
      logic [NODE_W-1:0] child;
   } entry_type;

   state_type state_ff, state_in;

   // node memory, one row per node
   logic [ROW_W-1:0]  node_mem [MAX_NODES];
   logic [ROW_W-1:0]  rd_row_ff;
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic [ROW_W-1:0]  wr_data;

   // word tracking state
   logic [NU_W-1:0]   nodes_used_ff, nodes_used_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [1:0]        spoiled_ff, spoiled_in;
   logic              missing_ff, missing_in;
   logic [NODE_W-1:0] clr_node_ff, clr_node_in;

   // registered letter
   logic              func_ff, func_in;
   logic              last_ff, last_in;
   tws_pkg::letter_code_type code_ff, code_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // evaluate-cycle decisions
   entry_type         cur_entry;
   entry_type         new_entry;
   logic [ROW_W-1:0]  row_upd;
   logic              req_take;
   logic              stall;
   logic              pool_full;
   logic              do_alloc;
   logic              do_mark;
   logic              write_parent;
   logic [1:0]        spoiled_nx;
   logic              missing_nx;
   logic [NODE_W-1:0] cursor_nx;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

   assign pool_full = (nodes_used_ff >= NU_W'(MAX_NODES));
   // a last letter waits while the previous result is still held
   assign stall     = last_ff && rsp_valid_ff && !rsp_ready;

   // link selection and the per-letter decision
   always_comb begin
      cur_entry  = rd_row_ff[code_ff.code * ENT_W +: ENT_W];
      spoiled_nx = spoiled_ff;
      missing_nx = missing_ff;
      cursor_nx  = cursor_ff;
      do_alloc   = 1'b0;
      if (spoiled_ff == tws_pkg::STATUS_OK) begin
         if (!code_ff.valid) begin
            spoiled_nx = tws_pkg::STATUS_BAD_LETTER;
         end else if (!missing_ff) begin
            if (cur_entry.child == '0) begin
               if (func_ff == FUNC_SEARCH) begin
                  missing_nx = 1'b1;
               end else if (pool_full) begin
                  spoiled_nx = tws_pkg::STATUS_POOL_FULL;
               end else begin
                  do_alloc  = 1'b1;
                  cursor_nx = nodes_used_ff[NODE_W-1:0];
               end
            end else begin
               cursor_nx = cur_entry.child;
            end
         end
      end

      // word-end bit lives in the parent slot that leads to the final node
      do_mark = last_ff && (func_ff == FUNC_INSERT) &&
                (spoiled_nx == tws_pkg::STATUS_OK) && !missing_nx;
      write_parent = do_alloc || do_mark;

      new_entry.child    = do_alloc ? nodes_used_ff[NODE_W-1:0] : cur_entry.child;
      new_entry.word_end = do_alloc ? do_mark : (cur_entry.word_end || do_mark);

      row_upd = rd_row_ff;
      row_upd[code_ff.code * ENT_W +: ENT_W] = new_entry;
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
         end
         ST_EVAL: begin
            wr_en   = write_parent && !stall;
            wr_addr = cursor_ff;
            wr_data = row_upd;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_node_ff;
         end
         ST_IDLE: begin
            wr_en = 1'b0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // next state and register inputs
   always_comb begin
      state_in      = state_ff;
      nodes_used_in = nodes_used_ff;
      cursor_in     = cursor_ff;
      spoiled_in    = spoiled_ff;
      missing_in    = missing_ff;
      clr_node_in   = clr_node_ff;
      func_in       = func_ff;
      last_in       = last_ff;
      code_in       = code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               func_in  = req_func;
               last_in  = req_last_letter;
               code_in  = tws_pkg::letter_decode(req_letter);
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!stall) begin
               cursor_in  = cursor_nx;
               spoiled_in = spoiled_nx;
               missing_in = missing_nx;
               if (do_alloc) begin
                  nodes_used_in = nodes_used_ff + NU_W'(1);
                  clr_node_in   = nodes_used_ff[NODE_W-1:0];
               end
               if (last_ff) begin
                  // result, then back to the root for the next word
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = spoiled_nx;
                  rsp_found_in  = (spoiled_nx == tws_pkg::STATUS_OK) && !missing_nx &&
                                  !do_alloc && cur_entry.word_end;
                  cursor_in     = '0;
                  spoiled_in    = tws_pkg::STATUS_OK;
                  missing_in    = 1'b0;
               end
               state_in = do_alloc ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         nodes_used_ff <= NU_W'(1);
         cursor_ff     <= '0;
         spoiled_ff    <= tws_pkg::STATUS_OK;
         missing_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         cursor_ff     <= cursor_in;
         spoiled_ff    <= spoiled_in;
         missing_ff    <= missing_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      clr_node_ff   <= clr_node_in;
      func_ff       <= func_in;
      last_ff       <= last_in;
      code_ff       <= code_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   // node memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (req_take) begin
         rd_row_ff <= node_mem[cursor_ff];
      end
   end

endmodule
